// File: hdl/oriented_rect_overlap_push_defines.svh
// Assertion macros used by the checker of this block.
`ifndef ORIENTED_RECT_OVERLAP_PUSH_DEFINES_SVH
`define ORIENTED_RECT_OVERLAP_PUSH_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define OROP_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("orop check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define OROP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("orop check failed");

`endif

// File: hdl/orop_pkg.sv
package orop_pkg;

	localparam int SINE_DEPTH_DEF = 256;
	localparam int COORD_W_DEF    = 32;

	// register stages from input beat to output beat
	localparam int PIPE_DEPTH = 6;

	localparam longint Q30_ONE = 64'sd1073741824;
	localparam longint POLY_C1 = 64'sd1686629713;
	localparam longint POLY_C3 = 64'sd693598668;
	localparam longint POLY_C5 = 64'sd85569306;
	localparam longint POLY_C7 = 64'sd5026995;
	localparam longint POLY_C9 = 64'sd172272;

	localparam longint OFFSET_LIMIT = 64'sd1099511627776;

	// sine of a/16384 of a quarter turn, Q1.15, odd polynomial in Q30
	function automatic longint quarter_sine(input longint a);
		longint t;
		longint t2;
		longint r;
		longint s;
		longint q;
		t  = a * 65536;
		t2 = t * t / Q30_ONE;
		r  = POLY_C9;
		r  = -POLY_C7 + r * t2 / Q30_ONE;
		r  = POLY_C5 + r * t2 / Q30_ONE;
		r  = -POLY_C3 + r * t2 / Q30_ONE;
		r  = POLY_C1 + r * t2 / Q30_ONE;
		s  = r * t / Q30_ONE;
		if (s < 0)
			s = 0;
		q = (s + 16384) >>> 15;
		if (q > 32767)
			q = 32767;
		return q;
	endfunction

	function automatic logic signed [15:0] phase_sine(input int phase);
		longint p;
		longint quad;
		longint a;
		longint v;
		p    = longint'(phase) & 64'hFFFF;
		quad = p >> 14;
		a    = p & 64'h3FFF;
		if (quad[0])
			a = 16384 - a;
		v = quarter_sine(a);
		if (quad[1])
			v = -v;
		return 16'(v);
	endfunction

	// |d| rounded half up from Q30 to Q15
	function automatic logic [16:0] round_abs_q15(input logic signed [32:0] d);
		logic [32:0] m;
		logic [32:0] r;
		m = d[32] ? 33'(-d) : 33'(d);
		r = m + 33'd16384;
		return r[31:15];
	endfunction

endpackage

// File: hdl/oriented_rect_overlap_push.sv
// Separating-axis overlap test of two yawed rectangles with minimum push. One box pair is
// taken per clock cycle while in_ready is high, and its result passes through the six
// register stages (yaw lookup, axis dot products, reach products, overlaps, minimum search,
// push multiply), which are kept to roughly one multiply or a few adds each. Every stage
// holds its beat only while the stage after it is full and stalled, so bubbles are squeezed
// out and the input keeps taking pairs while a result waits at the output, until all six
// stages are full. hit is 1 when all four axes overlap;
// push_x/push_z move box A out of B along the axis of least overlap, are zero without a
// hit, and saturate to the signed COORD_WIDTH range. Yaw is quantized to
// SINE_TABLE_DEPTH steps per turn through constant sine and cosine tables.
module oriented_rect_overlap_push #(
	parameter int SINE_TABLE_DEPTH = orop_pkg::SINE_DEPTH_DEF,
	parameter int COORD_WIDTH      = orop_pkg::COORD_W_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [COORD_WIDTH-1:0] a_center_x,
	input  logic signed [COORD_WIDTH-1:0] a_center_z,
	input  logic [30:0]                   a_half_x,
	input  logic [30:0]                   a_half_z,
	input  logic [15:0]                   a_yaw,
	input  logic signed [COORD_WIDTH-1:0] b_center_x,
	input  logic signed [COORD_WIDTH-1:0] b_center_z,
	input  logic [30:0]                   b_half_x,
	input  logic [30:0]                   b_half_z,
	input  logic [15:0]                   b_yaw,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          hit,
	output logic signed [COORD_WIDTH-1:0] push_x,
	output logic signed [COORD_WIDTH-1:0] push_z
);

	localparam int KW = $clog2(SINE_TABLE_DEPTH);
	localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1;
	localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;

	// ---------------- sine / cosine tables
	logic signed [15:0] sin_lut [SINE_TABLE_DEPTH];
	logic signed [15:0] cos_lut [SINE_TABLE_DEPTH];

	for (genvar g = 0; g < SINE_TABLE_DEPTH; g++) begin : g_lut
		localparam int PH = (g * 65536) / SINE_TABLE_DEPTH;
		assign sin_lut[g] = orop_pkg::phase_sine(PH);
		assign cos_lut[g] = orop_pkg::phase_sine(PH + 16384);
	end

	// ---------------- stage handshake
	logic [5:0] v_q;
	logic [5:0] adv;

	always_comb begin
		adv[5] = !v_q[5] || out_ready;
		for (int k = 4; k >= 0; k--)
			adv[k] = !v_q[k] || adv[k+1];
	end

	assign in_ready = adv[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (adv[0])
				v_q[0] <= in_valid;
			for (int k = 1; k < 6; k++) begin
				if (adv[k])
					v_q[k] <= v_q[k-1];
			end
		end
	end

	// ---------------- stage 1: table lookup, clamped offset
	logic [31:0]                  kprod_a;
	logic [31:0]                  kprod_b;
	logic [KW-1:0]                ka;
	logic [KW-1:0]                kb;
	logic signed [COORD_WIDTH:0]  dx;
	logic signed [COORD_WIDTH:0]  dz;
	logic signed [63:0]           dx_w;
	logic signed [63:0]           dz_w;
	logic signed [41:0]           ox_c;
	logic signed [41:0]           oz_c;

	always_comb begin
		kprod_a = 32'(a_yaw) * 32'(SINE_TABLE_DEPTH);
		kprod_b = 32'(b_yaw) * 32'(SINE_TABLE_DEPTH);
		ka      = kprod_a[16 +: KW];
		kb      = kprod_b[16 +: KW];
		dx      = $signed({a_center_x[COORD_WIDTH-1], a_center_x})
		        - $signed({b_center_x[COORD_WIDTH-1], b_center_x});
		dz      = $signed({a_center_z[COORD_WIDTH-1], a_center_z})
		        - $signed({b_center_z[COORD_WIDTH-1], b_center_z});
		dx_w    = 64'(dx);
		dz_w    = 64'(dz);
		if (dx_w > orop_pkg::OFFSET_LIMIT)
			dx_w = orop_pkg::OFFSET_LIMIT;
		else if (dx_w < -orop_pkg::OFFSET_LIMIT)
			dx_w = -orop_pkg::OFFSET_LIMIT;
		if (dz_w > orop_pkg::OFFSET_LIMIT)
			dz_w = orop_pkg::OFFSET_LIMIT;
		else if (dz_w < -orop_pkg::OFFSET_LIMIT)
			dz_w = -orop_pkg::OFFSET_LIMIT;
		ox_c = dx_w[41:0];
		oz_c = dz_w[41:0];
	end

	// axis order: uA, vA, uB, vB; wx = {ca, sa, cb, sb}, wz = {-sa, ca, -sb, cb}
	logic signed [15:0] wx_s1 [4];
	logic signed [15:0] wz_s1 [4];
	logic signed [41:0] ox_s1;
	logic signed [41:0] oz_s1;
	logic [30:0]        ahx_s1, ahz_s1, bhx_s1, bhz_s1;

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			wx_s1[0] <= cos_lut[ka];
			wz_s1[0] <= -sin_lut[ka];
			wx_s1[1] <= sin_lut[ka];
			wz_s1[1] <= cos_lut[ka];
			wx_s1[2] <= cos_lut[kb];
			wz_s1[2] <= -sin_lut[kb];
			wx_s1[3] <= sin_lut[kb];
			wz_s1[3] <= cos_lut[kb];
			ox_s1    <= ox_c;
			oz_s1    <= oz_c;
			ahx_s1   <= a_half_x;
			ahz_s1   <= a_half_z;
			bhx_s1   <= b_half_x;
			bhz_s1   <= b_half_z;
		end
	end

	// ---------------- stage 2: box axis dot products, projection products
	logic [16:0]        au_s2 [4];
	logic [16:0]        av_s2 [4];
	logic [16:0]        bu_s2 [4];
	logic [16:0]        bv_s2 [4];
	logic signed [57:0] px_s2 [4];
	logic signed [57:0] pz_s2 [4];
	logic signed [15:0] wx_s2 [4];
	logic signed [15:0] wz_s2 [4];
	logic [30:0]        ahx_s2, ahz_s2, bhx_s2, bhz_s2;

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			for (int i = 0; i < 4; i++) begin
				au_s2[i] <= orop_pkg::round_abs_q15(33'(wx_s1[0] * wx_s1[i])
				          - 33'(wx_s1[1] * wz_s1[i]));
				av_s2[i] <= orop_pkg::round_abs_q15(33'(wx_s1[1] * wx_s1[i])
				          + 33'(wx_s1[0] * wz_s1[i]));
				bu_s2[i] <= orop_pkg::round_abs_q15(33'(wx_s1[2] * wx_s1[i])
				          - 33'(wx_s1[3] * wz_s1[i]));
				bv_s2[i] <= orop_pkg::round_abs_q15(33'(wx_s1[3] * wx_s1[i])
				          + 33'(wx_s1[2] * wz_s1[i]));
				px_s2[i] <= 58'(ox_s1) * 58'(wx_s1[i]);
				pz_s2[i] <= 58'(oz_s1) * 58'(wz_s1[i]);
				wx_s2[i] <= wx_s1[i];
				wz_s2[i] <= wz_s1[i];
			end
			ahx_s2 <= ahx_s1;
			ahz_s2 <= ahz_s1;
			bhx_s2 <= bhx_s1;
			bhz_s2 <= bhz_s1;
		end
	end

	// ---------------- stage 3: reaches, centre projection
	logic [48:0]        ra_s3 [4];
	logic [48:0]        rb_s3 [4];
	logic signed [58:0] pj_s3 [4];
	logic signed [15:0] wx_s3 [4];
	logic signed [15:0] wz_s3 [4];

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			for (int i = 0; i < 4; i++) begin
				ra_s3[i] <= 49'(48'(ahx_s2) * 48'(au_s2[i])) + 49'(48'(ahz_s2) * 48'(av_s2[i]));
				rb_s3[i] <= 49'(48'(bhx_s2) * 48'(bu_s2[i])) + 49'(48'(bhz_s2) * 48'(bv_s2[i]));
				pj_s3[i] <= 59'(px_s2[i]) + 59'(pz_s2[i]);
				wx_s3[i] <= wx_s2[i];
				wz_s3[i] <= wz_s2[i];
			end
		end
	end

	// ---------------- stage 4: overlaps
	logic signed [60:0] ov_s4  [4];
	logic [3:0]         neg_s4;
	logic signed [15:0] wx_s4  [4];
	logic signed [15:0] wz_s4  [4];

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			for (int i = 0; i < 4; i++) begin
				ov_s4[i]  <= $signed(61'(ra_s3[i]) + 61'(rb_s3[i]))
				           - (pj_s3[i][58] ? -61'(pj_s3[i]) : 61'(pj_s3[i]));
				neg_s4[i] <= pj_s3[i][58];
				wx_s4[i]  <= wx_s3[i];
				wz_s4[i]  <= wz_s3[i];
			end
		end
	end

	// ---------------- stage 5: hit and axis of least overlap
	logic               hit_c;
	logic [1:0]         best;
	logic signed [60:0] ov_rnd;

	always_comb begin
		hit_c = 1'b1;
		best  = 2'd0;
		for (int i = 0; i < 4; i++) begin
			if (ov_s4[i] <= 61'sd0)
				hit_c = 1'b0;
		end
		// strict less-than keeps the earlier axis on a tie
		for (int i = 1; i < 4; i++) begin
			if (ov_s4[i] < ov_s4[best])
				best = 2'(i);
		end
		ov_rnd = ov_s4[best] + 61'sd16384;
	end

	logic               hit_s5;
	logic [35:0]        ov16_s5;
	logic signed [15:0] ax_s5;
	logic signed [15:0] az_s5;
	logic               neg_s5;

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			hit_s5  <= hit_c;
			ov16_s5 <= ov_rnd[50:15];
			ax_s5   <= wx_s4[best];
			az_s5   <= wz_s4[best];
			neg_s5  <= neg_s4[best];
		end
	end

	// ---------------- stage 6: push components, output register
	function automatic logic [COORD_WIDTH-1:0] push_comp(input logic signed [15:0] axis,
		input logic [35:0] ov16, input logic negate);
		logic [15:0]        mag_ax;
		logic [51:0]        mag;
		logic [51:0]        rnd;
		logic signed [63:0] v;
		mag_ax = axis[15] ? 16'(-axis) : 16'(axis);
		mag    = 52'(mag_ax) * 52'(ov16);
		rnd    = mag + 52'd16384;
		v      = 64'(rnd[51:15]);
		if (axis[15] != negate)
			v = -v;
		if (v > SAT_HI)
			v = SAT_HI;
		if (v < SAT_LO)
			v = SAT_LO;
		return v[COORD_WIDTH-1:0];
	endfunction

	logic                          hit_s6;
	logic signed [COORD_WIDTH-1:0] px_s6;
	logic signed [COORD_WIDTH-1:0] pz_s6;

	always_ff @(posedge clk) begin
		if (adv[5]) begin
			hit_s6 <= hit_s5;
			px_s6  <= hit_s5 ? push_comp(ax_s5, ov16_s5, neg_s5) : '0;
			pz_s6  <= hit_s5 ? push_comp(az_s5, ov16_s5, neg_s5) : '0;
		end
	end

	assign out_valid = v_q[5];
	assign hit       = hit_s6;
	assign push_x    = px_s6;
	assign push_z    = pz_s6;

endmodule

// File: hdl/orop_checker.sv
`include "oriented_rect_overlap_push_defines.svh"

module orop_checker #(
	parameter int COORD_WIDTH = orop_pkg::COORD_W_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic                          hit,
	input logic signed [COORD_WIDTH-1:0] push_x,
	input logic signed [COORD_WIDTH-1:0] push_z
);

	logic [2:0] cnt_q;
	logic       in_beat;
	logic       out_beat;

	assign in_beat  = in_valid && in_ready;
	assign out_beat = out_valid && out_ready;

	// count pairs inside the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + 3'(in_beat) - 3'(out_beat);
		end
	end

	`OROP_ASSERT_NOW(a_no_hit_zero, out_valid && !hit, push_x == '0 && push_z == '0)
	`OROP_ASSERT_NOW(a_out_has_item, out_valid, cnt_q != 3'd0)
	`OROP_ASSERT_NOW(a_depth_bound, 1'b1, cnt_q <= 3'(orop_pkg::PIPE_DEPTH))
	`OROP_ASSERT_NOW(a_ready_when_empty_out, !out_valid, in_ready)
	`OROP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(hit) && $stable(push_x) && $stable(push_z))

endmodule

bind oriented_rect_overlap_push orop_checker #(
	.COORD_WIDTH(COORD_WIDTH)
) u_orop_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.hit      (hit),
	.push_x   (push_x),
	.push_z   (push_z)
);

// File: tb/oriented_rect_overlap_push_test.sv
`timescale 1ns / 100ps

module oriented_rect_overlap_push_test;

	localparam int     TABLE_DEPTH = 256;
	localparam longint OFS_CLAMP   = 64'sd1 << 40;
	localparam longint PUSH_MAX    = 64'sd2147483647;
	localparam longint PUSH_MIN    = -64'sd2147483648;

	typedef struct packed {
		logic signed [31:0] ax;
		logic signed [31:0] az;
		logic [30:0]        ahx;
		logic [30:0]        ahz;
		logic [15:0]        ayaw;
		logic signed [31:0] bx;
		logic signed [31:0] bz;
		logic [30:0]        bhx;
		logic [30:0]        bhz;
		logic [15:0]        byaw;
	} box_pair_t;

	typedef struct packed {
		logic               hit;
		logic signed [31:0] px;
		logic signed [31:0] pz;
	} push_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic out_valid;
	logic out_ready = 1'b0;
	logic hit;
	logic signed [31:0] push_x, push_z;
	box_pair_t cur = '0;

	box_pair_t pending_pairs[$];
	push_t     expected_pushes[$];
	int idle_pct = 0;
	int stall_pct = 0;
	int errors = 0;

	oriented_rect_overlap_push dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.a_center_x(cur.ax), .a_center_z(cur.az), .a_half_x(cur.ahx), .a_half_z(cur.ahz),
		.a_yaw(cur.ayaw),
		.b_center_x(cur.bx), .b_center_z(cur.bz), .b_half_x(cur.bhx), .b_half_z(cur.bhz),
		.b_yaw(cur.byaw),
		.out_valid(out_valid), .out_ready(out_ready),
		.hit(hit), .push_x(push_x), .push_z(push_z)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// sine of a phase (65536 per turn) as Q1.15, odd polynomial on the first quadrant
	function automatic longint sine_q15(input longint phase);
		longint p, quad, a, t, t2, r, s, q;
		p = phase & 64'hFFFF;
		quad = p >> 14;
		a = p & 64'h3FFF;
		if (quad[0])
			a = 16384 - a;
		t = a * 65536;
		t2 = t * t / (64'sd1 << 30);
		r = 64'sd172272;
		r = -64'sd5026995 + r * t2 / (64'sd1 << 30);
		r = 64'sd85569306 + r * t2 / (64'sd1 << 30);
		r = -64'sd693598668 + r * t2 / (64'sd1 << 30);
		r = 64'sd1686629713 + r * t2 / (64'sd1 << 30);
		s = r * t / (64'sd1 << 30);
		if (s < 0)
			s = 0;
		q = (s + 16384) >>> 15;
		if (q > 32767)
			q = 32767;
		return quad[1] ? -q : q;
	endfunction

	function automatic longint mag_q15(input longint d);
		longint m;
		m = d < 0 ? -d : d;
		return (m + 16384) >>> 15;
	endfunction

	function automatic longint reach_q31(input longint hx, input longint hz, input longint c,
			input longint s, input longint wx, input longint wz);
		return hx * mag_q15(c * wx - s * wz) + hz * mag_q15(s * wx + c * wz);
	endfunction

	function automatic logic signed [31:0] push_part(input longint axis, input longint ov16,
			input bit negate);
		longint v;
		v = (((axis < 0) ? -axis : axis) * ov16 + 16384) >>> 15;
		if ((axis < 0) != negate)
			v = -v;
		if (v > PUSH_MAX)
			v = PUSH_MAX;
		if (v < PUSH_MIN)
			v = PUSH_MIN;
		return 32'(v);
	endfunction

	function automatic push_t predict_push(input box_pair_t bp);
		longint ca, sa, cb, sb, ox, oz, proj, ov16;
		longint wx[4], wz[4], ov[4];
		int best;
		bit separated;
		push_t res;
		ca = sine_q15((((longint'(bp.ayaw) * TABLE_DEPTH) >> 16) * 65536 / TABLE_DEPTH) + 16384);
		sa = sine_q15(((longint'(bp.ayaw) * TABLE_DEPTH) >> 16) * 65536 / TABLE_DEPTH);
		cb = sine_q15((((longint'(bp.byaw) * TABLE_DEPTH) >> 16) * 65536 / TABLE_DEPTH) + 16384);
		sb = sine_q15(((longint'(bp.byaw) * TABLE_DEPTH) >> 16) * 65536 / TABLE_DEPTH);
		ox = longint'(bp.ax) - longint'(bp.bx);
		oz = longint'(bp.az) - longint'(bp.bz);
		if (ox > OFS_CLAMP) ox = OFS_CLAMP;
		if (ox < -OFS_CLAMP) ox = -OFS_CLAMP;
		if (oz > OFS_CLAMP) oz = OFS_CLAMP;
		if (oz < -OFS_CLAMP) oz = -OFS_CLAMP;
		wx[0] = ca; wz[0] = -sa;
		wx[1] = sa; wz[1] = ca;
		wx[2] = cb; wz[2] = -sb;
		wx[3] = sb; wz[3] = cb;
		res = '0;
		best = 0;
		separated = 1'b0;
		for (int i = 0; i < 4; i++) begin
			if (!separated) begin
				proj = ox * wx[i] + oz * wz[i];
				if (proj < 0)
					proj = -proj;
				ov[i] = reach_q31(longint'(bp.ahx), longint'(bp.ahz), ca, sa, wx[i], wz[i])
					+ reach_q31(longint'(bp.bhx), longint'(bp.bhz), cb, sb, wx[i], wz[i]) - proj;
				if (ov[i] <= 0)
					separated = 1'b1;
				else if (ov[i] < ov[best])
					best = i;
			end
		end
		if (!separated) begin
			ov16 = (ov[best] + 16384) >>> 15;
			res.hit = 1'b1;
			res.px = push_part(wx[best], ov16, (ox * wx[best] + oz * wz[best]) < 0);
			res.pz = push_part(wz[best], ov16, (ox * wx[best] + oz * wz[best]) < 0);
		end
		return res;
	endfunction

	// mostly close pairs so the axes actually overlap; some wide noise and big boxes
	function automatic box_pair_t random_pair();
		box_pair_t bp;
		int mode;
		bp.ax   = 32'($urandom);
		bp.az   = 32'($urandom);
		bp.ahx  = 31'($urandom);
		bp.ahz  = 31'($urandom);
		bp.ayaw = 16'($urandom);
		bp.bx   = 32'($urandom);
		bp.bz   = 32'($urandom);
		bp.bhx  = 31'($urandom);
		bp.bhz  = 31'($urandom);
		bp.byaw = 16'($urandom);
		mode = $urandom_range(0, 9);
		if (mode < 6) begin
			bp.bx = bp.ax + $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
			bp.bz = bp.az + $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
			bp.ahx = 31'($urandom_range(0, 32'h0030_0000));
			bp.ahz = 31'($urandom_range(0, 32'h0030_0000));
			bp.bhx = 31'($urandom_range(0, 32'h0030_0000));
			bp.bhz = 31'($urandom_range(0, 32'h0030_0000));
		end else if (mode < 8) begin
			bp.bx = bp.ax + $signed(32'($urandom_range(0, 32'h7FFF_FFFF)) >>> 1);
			bp.bz = bp.az - $signed(32'($urandom_range(0, 32'h7FFF_FFFF)) >>> 1);
		end
		return bp;
	endfunction

	// driver: take a new beat once the old one is gone
	always @(posedge clk) begin
		if (arst_n && (!in_valid || in_ready)) begin
			if (pending_pairs.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
				cur <= pending_pairs.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_ready <= arst_n && ($urandom_range(0, 99) >= stall_pct);
	end

	// monitor
	always @(posedge clk) begin
		push_t want;
		if (arst_n && in_valid && in_ready)
			expected_pushes.push_back(predict_push(cur));
		if (arst_n && out_valid && out_ready) begin
			if (expected_pushes.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected beat hit=%0d push=(%0d,%0d)", hit, push_x, push_z);
			end else begin
				want = expected_pushes.pop_front();
				if (hit !== want.hit || push_x !== want.px || push_z !== want.pz) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: exp hit=%0d push=(%0d,%0d) got hit=%0d push=(%0d,%0d)",
							want.hit, want.px, want.pz, hit, push_x, push_z);
				end
			end
		end
	end

	initial begin
		box_pair_t bp;
		int phase_idle[4] = '{0, 70, 0, 20};
		int phase_stall[4] = '{0, 0, 70, 20};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// all zero: touching only, no hit
		bp = '0;
		pending_pairs.push_back(bp);
		// same centre, unit boxes, A yawed in quarter turns, B at other yaws: ties on equal overlaps
		for (int y = 0; y < 5; y++) begin
			bp = '0;
			bp.ahx = 31'h1_0000; bp.ahz = 31'h1_0000;
			bp.bhx = 31'h1_0000; bp.bhz = 31'h1_0000;
			bp.ayaw = (y == 4) ? 16'hFFFF : 16'(y * 16384);
			bp.byaw = 16'(y * 12000);
			pending_pairs.push_back(bp);
		end
		// largest boxes: push saturates; A right of B, then left of and below B
		bp = '0;
		bp.ahx = '1; bp.ahz = '1; bp.bhx = '1; bp.bhz = '1;
		bp.ax = 32'sh4000_0000; bp.bx = -32'sh4000_0000;
		pending_pairs.push_back(bp);
		bp.ax = -32'sh4000_0000; bp.bx = 32'sh4000_0000;
		bp.az = -32'sh1000; bp.ayaw = 16'h2000;
		pending_pairs.push_back(bp);
		// far centres at both coordinate extremes
		bp.ax = 32'sh7FFF_FFFF; bp.bx = -32'sh8000_0000;
		bp.az = -32'sh8000_0000; bp.bz = 32'sh7FFF_FFFF;
		pending_pairs.push_back(bp);
		// tiny overlap: boxes of half size 1, small push
		bp = '0;
		bp.ahx = 31'd1; bp.ahz = 31'd1; bp.bhx = 31'd1; bp.bhz = 31'd1;
		pending_pairs.push_back(bp);
		bp.ax = 32'sd1; bp.byaw = 16'h8000;
		pending_pairs.push_back(bp);
		// just touching along x: no hit; then a shallow overlap
		bp = '0;
		bp.ahx = 31'h1_0000; bp.ahz = 31'h1_0000; bp.bhx = 31'h1_0000; bp.bhz = 31'h1_0000;
		bp.ax = 32'sh2_0000;
		pending_pairs.push_back(bp);
		bp.ax = 32'sh1_8000; bp.az = -32'sh0_4000;
		pending_pairs.push_back(bp);

		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = phase_idle[ph];
			stall_pct = phase_stall[ph];
			for (int n = 0; n < 160; n++)
				pending_pairs.push_back(random_pair());
			// check on the falling edge, away from the driver's updates
			do
				@(negedge clk);
			while (pending_pairs.size() != 0 || in_valid || expected_pushes.size() != 0);
			@(posedge clk);
		end
		repeat (orop_pkg::PIPE_DEPTH * 4) @(posedge clk);
		if (errors == 0 && expected_pushes.size() == 0)
			$display("PASS oriented_rect_overlap_push");
		else
			$display("FAIL oriented_rect_overlap_push");
		$finish;
	end

	initial begin
		#2ms;
		$display("FAIL oriented_rect_overlap_push");
		$finish;
	end

endmodule

// File: oriented_rect_overlap_push.f
+incdir+hdl
hdl/orop_pkg.sv
hdl/oriented_rect_overlap_push.sv
hdl/orop_checker.sv
tb/oriented_rect_overlap_push_test.sv
